[hdl/bkr_pkg.sv]
// Shared types, sizes and codes for the banker's request checker.
`timescale 1ns / 1ps

package bkr_pkg;

  localparam int NUM_PROCS   = 4;
  localparam int NUM_RES     = 3;
  localparam int COUNT_WIDTH = 8;
  localparam int PROC_W      = $clog2(NUM_PROCS);
  // avail plus every allocation never exceeds (NUM_PROCS + 1) full counts
  localparam int WORK_W      = COUNT_WIDTH + $clog2(NUM_PROCS + 1);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef count_t [NUM_RES-1:0]   row_t;
  typedef row_t [NUM_PROCS-1:0]   table_t;
  typedef logic [PROC_W-1:0]      proc_t;
  typedef logic [WORK_W-1:0]      work_t;
  typedef work_t [NUM_RES-1:0]    work_vec_t;
  typedef logic [NUM_PROCS-1:0]   proc_mask_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SET    = 2'd1,
    OP_REQ    = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_OVER_NEED = 3'd1,
    ST_OVER_AVL  = 3'd2,
    ST_UNSAFE    = 3'd3,
    ST_LOADED    = 3'd4
  } status_t;

  // result of one merge step over the lanes
  typedef struct packed {
    logic       any_fit;
    proc_mask_t grant;
  } pick_t;

endpackage

[hdl/bkr_if.sv]
// Valid/ready channel interfaces for the request and result transactions.
`timescale 1ns / 1ps

interface bkr_in_if;
  import bkr_pkg::*;
  logic   valid;
  logic   ready;
  logic [1:0] op;
  proc_t  process;
  count_t amount0;
  count_t amount1;
  count_t amount2;
  count_t need0;
  count_t need1;
  count_t need2;

  modport source (output valid, output op, output process, output amount0,
                  output amount1, output amount2, output need0, output need1,
                  output need2, input ready);
  modport sink   (input valid, input op, input process, input amount0,
                  input amount1, input amount2, input need0, input need1,
                  input need2, output ready);
endinterface

interface bkr_out_if;
  import bkr_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  count_t     avail_out0;
  count_t     avail_out1;
  count_t     avail_out2;

  modport source (output valid, output status, output avail_out0,
                  output avail_out1, output avail_out2, input ready);
  modport sink   (input valid, input status, input avail_out0,
                  input avail_out1, input avail_out2, output ready);
endinterface

[hdl/bankers_request_check_core.sv]
// Top level of the banker's deadlock-avoidance request checker.
`timescale 1ns / 1ps

// Banker's request checker. Holds an availability vector plus per-process
// allocation and remaining-need rows, all zero after reset. Op 0 loads one
// process's rows, op 1 sets availability, op 2 asks for amounts; every
// transaction returns one result with a status and the availability after
// the step. Load, set, unused op and rejected requests write their result
// straight from the idle state, with no search. An admissible request is
// applied tentatively and then runs the safety search: one lane per
// process tests need against the work vector, and the merge stage grants
// the lowest fitting process and adds its allocation, one grant per cycle.
// The search ends when no unfinished process fits; an unsafe outcome then
// rolls the rows back. The input is ready only while no search runs and
// the result register is empty or being drained.

module bankers_request_check_core (
  input  logic             clk,
  input  logic             rst_n,
  bkr_in_if.sink           in_ch,
  bkr_out_if.source        out_ch
);
  import bkr_pkg::*;

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t    state_r;
  row_t      avail_r;
  table_t    alloc_r;
  table_t    need_r;
  work_vec_t work_r;
  proc_mask_t done_r;
  proc_t     proc_r;
  row_t      old_avail_r;
  row_t      old_alloc_r;
  row_t      old_need_r;
  logic      out_valid_r;
  status_t   status_r;
  row_t      avail_out_r;

  logic      accept;
  op_t       op_in;
  row_t      req;
  row_t      load_need;
  logic      over_need;
  logic      over_avail;
  row_t      avail_nxt;
  row_t      need_nxt;
  row_t      alloc_nxt;
  proc_mask_t fit;
  pick_t     pick;
  work_vec_t work_nxt;
  logic [COUNT_WIDTH:0] sum;
  logic      out_load;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign op_in       = op_t'(in_ch.op);

  assign req       = {in_ch.amount2, in_ch.amount1, in_ch.amount0};
  assign load_need = {in_ch.need2, in_ch.need1, in_ch.need0};

  // admission checks and the tentative update for the addressed process
  always_comb begin
    over_need  = 1'b0;
    over_avail = 1'b0;
    for (int r = 0; r < NUM_RES; r++) begin
      if (req[r] > need_r[in_ch.process][r]) over_need = 1'b1;
      if (req[r] > avail_r[r]) over_avail = 1'b1;
      avail_nxt[r] = avail_r[r] - req[r];
      need_nxt[r]  = need_r[in_ch.process][r] - req[r];
      sum          = {1'b0, alloc_r[in_ch.process][r]} + {1'b0, req[r]};
      // saturate at the largest count
      alloc_nxt[r] = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    end
  end

  // a result is written by a load, set or unused op, a rejected request or the end of a search
  always_comb begin
    if (state_r == S_IDLE) begin
      out_load = accept && !(op_in == OP_REQ && !over_need && !over_avail);
    end else begin
      out_load = !pick.any_fit;
    end
  end

  // one lane per process
  for (genvar p = 0; p < NUM_PROCS; p++) begin : g_lane
    bkr_lane u_lane (
      .need_row (need_r[p]),
      .work     (work_r),
      .done     (done_r[p]),
      .fit      (fit[p])
    );
  end

  bkr_merge u_merge (
    .fit      (fit),
    .alloc    (alloc_r),
    .work     (work_r),
    .pick     (pick),
    .work_nxt (work_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      avail_r     <= '0;
      alloc_r     <= '0;
      need_r      <= '0;
      done_r      <= '0;
    end else begin
      // load or drain the result register
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (op_in)
              OP_LOAD: begin
                alloc_r[in_ch.process] <= req;
                need_r[in_ch.process]  <= load_need;
                status_r    <= ST_LOADED;
                avail_out_r <= avail_r;
              end
              OP_SET: begin
                avail_r     <= req;
                status_r    <= ST_LOADED;
                avail_out_r <= req;
              end
              OP_REQ: begin
                if (over_need || over_avail) begin
                  status_r    <= over_need ? ST_OVER_NEED : ST_OVER_AVL;
                  avail_out_r <= avail_r;
                end else begin
                  // apply tentatively, keep the old rows for rollback
                  old_avail_r <= avail_r;
                  old_alloc_r <= alloc_r[in_ch.process];
                  old_need_r  <= need_r[in_ch.process];
                  proc_r      <= in_ch.process;
                  avail_r     <= avail_nxt;
                  need_r[in_ch.process]  <= need_nxt;
                  alloc_r[in_ch.process] <= alloc_nxt;
                  for (int r = 0; r < NUM_RES; r++) begin
                    work_r[r] <= work_t'(avail_nxt[r]);
                  end
                  done_r  <= '0;
                  state_r <= S_SEARCH;
                end
              end
              default: begin
                status_r    <= ST_LOADED;
                avail_out_r <= avail_r;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (pick.any_fit) begin
            // advance: finish the granted process
            done_r <= done_r | pick.grant;
            work_r <= work_nxt;
          end else begin
            state_r     <= S_IDLE;
            if (&done_r) begin
              status_r    <= ST_GRANTED;
              avail_out_r <= avail_r;
            end else begin
              // drop the request: restore the exact old rows
              status_r        <= ST_UNSAFE;
              avail_out_r     <= old_avail_r;
              avail_r         <= old_avail_r;
              alloc_r[proc_r] <= old_alloc_r;
              need_r[proc_r]  <= old_need_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.avail_out0 = avail_out_r[0];
  assign out_ch.avail_out1 = avail_out_r[1];
  assign out_ch.avail_out2 = avail_out_r[2];

endmodule

[hdl/bkr_lane.sv]
// One safety-search lane: does an unfinished process's need fit the work vector.
`timescale 1ns / 1ps

module bkr_lane (
  input  bkr_pkg::row_t      need_row,
  input  bkr_pkg::work_vec_t work,
  input  logic               done,
  output logic               fit
);
  import bkr_pkg::*;

  always_comb begin
    fit = !done;
    for (int r = 0; r < NUM_RES; r++) begin
      if (work_t'(need_row[r]) > work[r]) fit = 1'b0;
    end
  end

endmodule

[hdl/bkr_merge.sv]
// Merge stage: pick the lowest fitting lane and add its allocation to work.
`timescale 1ns / 1ps

module bkr_merge (
  input  bkr_pkg::proc_mask_t fit,
  input  bkr_pkg::table_t     alloc,
  input  bkr_pkg::work_vec_t  work,
  output bkr_pkg::pick_t      pick,
  output bkr_pkg::work_vec_t  work_nxt
);
  import bkr_pkg::*;

  row_t sel_row;

  always_comb begin
    pick.any_fit = |fit;
    pick.grant   = fit & (~fit + proc_mask_t'(1));
    sel_row      = '0;
    for (int p = 0; p < NUM_PROCS; p++) begin
      if (pick.grant[p]) sel_row = sel_row | alloc[p];
    end
    for (int r = 0; r < NUM_RES; r++) begin
      work_nxt[r] = work[r] + work_t'(sel_row[r]);
    end
  end

endmodule
